### rtl/core/tcld_pkg.sv
// Shared types, constants and address helper for the tiled canvas line draw block.
// Used by tcld_div, tcld_canvas and tiled_canvas_line_draw.
`default_nettype none
package tcld_pkg;

	localparam int ADDR_W      = 14;
	localparam int CANVAS_DEPTH = 1 << ADDR_W;
	localparam int COORD_W     = 7;
	localparam int PIX_W       = 8;
	localparam int FRAC_W      = 9;
	localparam int DIVD_W      = COORD_W + 8;
	localparam int CNT_W       = 4;

	localparam logic [COORD_W-1:0] ROW_MAX    = 7'd127;
	localparam logic [FRAC_W-1:0]  FRAC_START = 9'h080;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [PIX_W-1:0]   pix_t;

	typedef enum logic [1:0] {
		CMD_DRAW  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		pix_t  data;
	} canvas_wr_t;

	// 8x8 tiles, 16 tiles per row: {ty, tx, y in tile, x in tile}
	function automatic addr_t tile_addr(input coord_t x, input coord_t y);
		return {y[6:3], x[6:3], y[2:0], x[2:0]};
	endfunction

endpackage
`default_nettype wire

### rtl/core/tcld_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tcld_pkg for widths.
`default_nettype none
module tcld_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tcld_pkg::DIVD_W-1:0] dividend,
	input  wire tcld_pkg::coord_t            divisor,
	output logic                             done,
	output logic [tcld_pkg::DIVD_W-1:0]      quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [tcld_pkg::CNT_W-1:0]    cnt_q;
	tcld_pkg::coord_t              rem_q;
	tcld_pkg::coord_t              dvs_q;
	logic [tcld_pkg::DIVD_W-1:0]   quo_q;

	logic [tcld_pkg::COORD_W:0]    trial;
	logic                          ge;

	assign trial = {rem_q, quo_q[tcld_pkg::DIVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tcld_pkg::CNT_W'(tcld_pkg::DIVD_W);
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
			end else if (busy_q) begin
				// remainder stays below the divisor, so 7 bits hold it
				rem_q <= ge ? tcld_pkg::COORD_W'(trial - {1'b0, dvs_q})
				            : trial[tcld_pkg::COORD_W-1:0];
				quo_q <= {quo_q[tcld_pkg::DIVD_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tcld_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### rtl/core/tcld_canvas.sv
// Canvas byte store: one write port, one read port with registered data.
// Depends on tcld_pkg for the depth and the write request struct.
`default_nettype none
module tcld_canvas (
	input  wire logic                clk,
	input  wire tcld_pkg::canvas_wr_t wr,
	input  wire logic                rd_en,
	input  wire tcld_pkg::addr_t     rd_addr,
	output tcld_pkg::pix_t           rd_data
);

	tcld_pkg::pix_t mem [tcld_pkg::CANVAS_DEPTH];
	tcld_pkg::pix_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### rtl/core/tiled_canvas_line_draw.sv
// Tiled canvas line rasterizer top level: sequencer, setup, pixel loop, output register.
// Depends on tcld_pkg, tcld_div, tcld_canvas. One command at a time, one result beat each.
// A non-empty draw passes through setup, the divider and the pixel loop before its result beat.
// The pixel loop does one read-max-write per cycle on the single canvas port pair.
// A new command is accepted only after the previous result is loaded for output.
// Reset: async, active low; a clearing pass then zeroes the canvas, not ready meanwhile.
`default_nettype none
module tiled_canvas_line_draw (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_ready,
	input  wire logic [1:0]              command,
	input  wire logic [6:0]              start_x,
	input  wire logic signed [9:0]       start_y,
	input  wire logic [6:0]              end_x,
	input  wire logic signed [9:0]       end_y,
	input  wire logic [7:0]              pen_value,
	input  wire logic [13:0]             byte_address,
	input  wire logic [7:0]              byte_data,
	output logic                         rsp_valid,
	input  wire logic                    rsp_ready,
	output logic [7:0]                   read_value
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_ORIENT,
		S_DIV,
		S_DRAW,
		S_DRAIN,
		S_MEMOP,
		S_RDWAIT,
		S_DONE
	} state_t;

	state_t state_q;

	// captured command beat
	logic [1:0]              cmd_q;
	tcld_pkg::coord_t        x0_q, x1_q;
	logic signed [9:0]       y0_q, y1_q;
	tcld_pkg::pix_t          pen_q;
	tcld_pkg::addr_t         addr_q;
	tcld_pkg::pix_t          data_q;

	// setup results
	tcld_pkg::coord_t        yc0_q, yc1_q;
	logic                    ymaj_q;   // y is the major axis
	logic                    swap_q;
	logic                    dirpos_q; // minor coordinate steps upward

	// pixel loop
	tcld_pkg::coord_t        maj_q, maj_end_q, min_q;
	logic [tcld_pkg::FRAC_W-1:0] frac_q, step_q;

	// read-modify-write pipe: read issued in one cycle, write back in the next
	logic                    pend_s1;
	tcld_pkg::addr_t         pend_addr_s1;

	tcld_pkg::addr_t         clr_q;
	tcld_pkg::pix_t          res_q;
	logic                    rsp_valid_q;
	tcld_pkg::pix_t          read_value_q;

	// ---------------- setup, first cycle: deltas, clamps, axis, direction
	logic signed [7:0]       dx;
	logic signed [10:0]      dy;
	logic [7:0]              adx;
	logic [10:0]             ady;
	tcld_pkg::coord_t        yc0, yc1;
	logic                    ymaj, swap, dirpos;

	function automatic tcld_pkg::coord_t clamp_row(input logic signed [9:0] v);
		if (v[9])
			return '0;
		else if (v[8:7] != 2'b00)
			return tcld_pkg::ROW_MAX;
		else
			return v[6:0];
	endfunction

	always_comb begin
		dx   = $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
		dy   = $signed({y1_q[9], y1_q}) - $signed({y0_q[9], y0_q});
		adx  = dx[7] ? 8'(-dx) : 8'(dx);
		ady  = dy[10] ? 11'(-dy) : 11'(dy);
		yc0  = clamp_row(y0_q);
		yc1  = clamp_row(y1_q);
		ymaj = {3'b000, adx} < ady;
		swap = ymaj ? dy[10] : dx[7];
		// After a swap the minor delta is re-taken from the swapped endpoints:
		// x is unclamped, so that is just the negated raw dx; for y it uses the
		// clamped rows. Without a swap the raw delta decides.
		if (ymaj)
			dirpos = swap ? dx[7] : (!dx[7] && dx != 8'sd0);
		else
			dirpos = swap ? (yc0 > yc1) : (!dy[10] && dy != 11'sd0);
	end

	// ---------------- setup, second cycle: ordered endpoints, span, minor size
	tcld_pkg::coord_t        ax, bx, ay, by;
	tcld_pkg::coord_t        majs, maje, mins, mine;
	tcld_pkg::coord_t        span, num;
	logic                    go;

	always_comb begin
		ax   = swap_q ? x1_q  : x0_q;
		bx   = swap_q ? x0_q  : x1_q;
		ay   = swap_q ? yc1_q : yc0_q;
		by   = swap_q ? yc0_q : yc1_q;
		majs = ymaj_q ? ay : ax;
		maje = ymaj_q ? by : bx;
		mins = ymaj_q ? ax : ay;
		mine = ymaj_q ? bx : by;
		// empty or descending clamped span draws nothing; divider never sees zero
		go   = maje > majs;
		span = maje - majs;
		num  = (mins > mine) ? mins - mine : mine - mins;
	end

	// ---------------- divider: step = (|minor| << 8) / major span
	logic                           div_start, div_done;
	logic [tcld_pkg::DIVD_W-1:0]    div_quo;

	assign div_start = (state_q == S_ORIENT) && go;

	tcld_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({num, 8'h00}),
		.divisor  (span),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- pixel step
	// Only bit 8 of the fraction is ever tested and carries only move upward,
	// so 9 bits of fraction and of step give the same carries as the full word.
	logic [tcld_pkg::FRAC_W-1:0]    fsum;
	tcld_pkg::coord_t               maj_nxt;
	tcld_pkg::coord_t               px, py;
	tcld_pkg::addr_t                pix_addr;

	assign fsum     = frac_q + step_q;
	assign maj_nxt  = maj_q + 1'b1;
	assign px       = ymaj_q ? min_q : maj_q;
	assign py       = ymaj_q ? maj_q : min_q;
	assign pix_addr = tcld_pkg::tile_addr(px, py);

	// ---------------- canvas port steering
	tcld_pkg::canvas_wr_t           mem_wr;
	logic                           mem_rd_en;
	tcld_pkg::addr_t                mem_rd_addr;
	tcld_pkg::pix_t                 mem_rd_data;

	always_comb begin
		mem_wr      = '0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = pix_addr;
		if (state_q == S_CLEAR) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = clr_q;
			mem_wr.data = '0;
		end else if (pend_s1) begin
			// write back the larger of the old byte and the pen
			mem_wr.en   = 1'b1;
			mem_wr.addr = pend_addr_s1;
			mem_wr.data = (pen_q > mem_rd_data) ? pen_q : mem_rd_data;
		end else if (state_q == S_MEMOP && cmd_q == tcld_pkg::CMD_WRITE) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = addr_q;
			mem_wr.data = data_q;
		end
		if (state_q == S_DRAW) begin
			mem_rd_en = 1'b1;
		end else if (state_q == S_MEMOP && cmd_q == tcld_pkg::CMD_READ) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = addr_q;
		end
	end

	tcld_canvas u_canvas (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// ---------------- sequencer and registers
	logic                           cmd_fire;
	logic                           out_free;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_DRAW);
			// S_DONE reloads the output register itself when it is free
			if (rsp_valid_q && rsp_ready && state_q != S_DONE)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == tcld_pkg::addr_t'(tcld_pkg::CANVAS_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_fire) begin
						cmd_q  <= command;
						x0_q   <= start_x;
						y0_q   <= start_y;
						x1_q   <= end_x;
						y1_q   <= end_y;
						pen_q  <= pen_value;
						addr_q <= byte_address;
						data_q <= byte_data;
						res_q  <= '0;
						case (command) inside
							tcld_pkg::CMD_DRAW:                      state_q <= S_PREP;
							tcld_pkg::CMD_WRITE, tcld_pkg::CMD_READ: state_q <= S_MEMOP;
							default:                                 state_q <= S_DONE;
						endcase
					end
				end
				S_PREP: begin
					yc0_q    <= yc0;
					yc1_q    <= yc1;
					ymaj_q   <= ymaj;
					swap_q   <= swap;
					dirpos_q <= dirpos;
					state_q  <= S_ORIENT;
				end
				S_ORIENT: begin
					maj_q     <= majs;
					maj_end_q <= maje;
					min_q     <= mins;
					frac_q    <= tcld_pkg::FRAC_START;
					state_q   <= go ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						step_q  <= div_quo[tcld_pkg::FRAC_W-1:0];
						state_q <= S_DRAW;
					end
				end
				S_DRAW: begin
					// read for this pixel goes out now; write back lands next cycle
					pend_addr_s1 <= pix_addr;
					maj_q        <= maj_nxt;
					if (fsum[tcld_pkg::FRAC_W-1]) begin
						min_q  <= dirpos_q ? min_q + 1'b1 : min_q - 1'b1;
						frac_q <= {1'b0, fsum[tcld_pkg::FRAC_W-2:0]};
					end else begin
						frac_q <= fsum;
					end
					// last pixel is not drawn
					if (maj_nxt == maj_end_q)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_MEMOP: begin
					state_q <= (cmd_q == tcld_pkg::CMD_READ) ? S_RDWAIT : S_DONE;
				end
				S_RDWAIT: begin
					res_q   <= mem_rd_data;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold here only while the previous result is still unclaimed
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						read_value_q <= res_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_ready  = (state_q == S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;

endmodule
`default_nettype wire

### tb/tcld_canvas_check.sv
`timescale 1ns / 100ps
// Response checker for the tiled canvas line draw block: mirrors the canvas and predicts read bytes.
// Depends on tcld_pkg; instantiated by tb next to the block and hands back its failure count.
module tcld_canvas_check
	import tcld_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire logic              cmd_ready,
	input  wire logic [1:0]        command,
	input  wire logic [6:0]        start_x,
	input  wire logic signed [9:0] start_y,
	input  wire logic [6:0]        end_x,
	input  wire logic signed [9:0] end_y,
	input  wire logic [7:0]        pen_value,
	input  wire logic [13:0]       byte_address,
	input  wire logic [7:0]        byte_data,
	input  wire logic              rsp_valid,
	input  wire logic              rsp_ready,
	input  wire logic [7:0]        read_value,
	output int                     fail_count,
	output int                     pending
);

	localparam int unsigned FRAC_CARRY = 'h100;

	pix_t canvas_model [CANVAS_DEPTH] = '{default: '0};
	pix_t expected_bytes [$];
	int   fails = 0;

	function automatic int clamp_row(input int v);
		if (v < 0) return 0;
		if (v > int'(ROW_MAX)) return int'(ROW_MAX);
		return v;
	endfunction

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// pixel keeps the larger of old byte and pen
	function automatic void plot_max(input int x, input int y, input pix_t pen);
		int ux, uy, a;
		ux = x & 127;
		uy = y & 127;
		a = ((uy >> 3) << 10) + ((ux >> 3) << 6) + ((uy & 7) << 3) + (ux & 7);
		if (canvas_model[a] < pen) canvas_model[a] = pen;
	endfunction

	function automatic void rasterize_line(input int x0, input int y0, input int x1,
		input int y1, input pix_t pen);
		int dx, dy, t, span, major, minor;
		int unsigned frac, step;
		dx = x1 - x0;
		dy = y1 - y0;
		y0 = clamp_row(y0);
		y1 = clamp_row(y1);
		frac = int'(FRAC_START);
		if (magnitude(dx) < magnitude(dy)) begin
			if (dy < 0) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
				dx = x1 - x0;
			end
			span = magnitude(y1 - y0);
			if (span == 0 || y0 >= y1) return;
			step = (magnitude(x1 - x0) << 8) / span;
			minor = x0;
			for (major = y0; major != y1; major++) begin
				plot_max(minor, major, pen);
				frac += step;
				if (frac & FRAC_CARRY) begin
					minor += (dx > 0) ? 1 : -1;
					frac &= ~FRAC_CARRY;
				end
			end
		end else begin
			if (dx < 0) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
				dy = y1 - y0;
				dx = x1 - x0;
			end
			span = magnitude(x1 - x0);
			if (span == 0 || x0 >= x1) return;
			step = (magnitude(y1 - y0) << 8) / span;
			minor = y0;
			for (major = x0; major != x1; major++) begin
				plot_max(major, minor, pen);
				frac += step;
				if (frac & FRAC_CARRY) begin
					minor += (dy > 0) ? 1 : -1;
					frac &= ~FRAC_CARRY;
				end
			end
		end
	endfunction

	// response beat is retired before a command beat on the same edge
	always @(posedge clk) begin
		pix_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_bytes.size() == 0) begin
					fails++;
					$display("%0t: response beat with nothing outstanding, expected none, actual %0d",
						$time, read_value);
				end else begin
					want = expected_bytes.pop_front();
					if (read_value !== want) begin
						fails++;
						$display("%0t: read_value mismatch, expected %0d, actual %0d",
							$time, want, read_value);
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				want = '0;
				case (cmd_t'(command))
					CMD_DRAW: rasterize_line(int'(start_x), int'(start_y), int'(end_x),
						int'(end_y), pen_value);
					CMD_WRITE: canvas_model[byte_address] = byte_data;
					CMD_READ: want = canvas_model[byte_address];
					CMD_NONE: ;
					default: ;
				endcase
				expected_bytes.push_back(want);
			end
		end
		fail_count <= fails;
		pending <= expected_bytes.size();
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for tiled_canvas_line_draw: clock, reset, command stimulus, response pacing.
// Depends on tcld_pkg, the block itself and tcld_canvas_check, which does all the checking.
module tb;
	import tcld_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1500000;
	localparam int          RANDOM_ITEMS = 1750;
	// room after the longest draw, for a stalled response
	localparam int          DRAIN_CYCLES = 200;
	localparam int          LONG_HOLD    = 600;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              cmd_valid    = 1'b0;
	logic              cmd_ready;
	logic [1:0]        command      = CMD_NONE;
	logic [6:0]        start_x      = '0;
	logic signed [9:0] start_y      = '0;
	logic [6:0]        end_x        = '0;
	logic signed [9:0] end_y        = '0;
	logic [7:0]        pen_value    = '0;
	logic [13:0]       byte_address = '0;
	logic [7:0]        byte_data    = '0;
	logic              rsp_valid;
	logic              rsp_ready    = 1'b0;
	logic [7:0]        read_value;

	int          fail_count;
	int          pending;
	int unsigned cycle_count = 0;
	bit          sender_calm = 1'b0;

	tiled_canvas_line_draw dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.pen_value    (pen_value),
		.byte_address (byte_address),
		.byte_data    (byte_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.read_value   (read_value)
	);

	tcld_canvas_check checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.pen_value    (pen_value),
		.byte_address (byte_address),
		.byte_data    (byte_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.read_value   (read_value),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: the block clears its canvas after reset, then runs one command at a time;
	// with both sides idling, this limit is several times over what the run needs
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// tiled byte offset of pixel (x,y): 8x8 tiles, 16 across
	function automatic int pixel_addr(input int x, input int y);
		return ((y & 'h78) << 7) | ((x & 'h78) << 3) | ((y & 7) << 3) | (x & 7);
	endfunction

	// Offer one command beat after a random gap; valid stays up until the beat is taken.
	// Fields a command does not use still carry whatever the caller passes (usually noise).
	task automatic send_cmd(input cmd_t op, input int sx, input int sy, input int ex,
		input int ey, input int pen, input int addr, input int data);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid    <= 1'b1;
		command      <= op;
		start_x      <= 7'(sx);
		start_y      <= 10'(sy);
		end_x        <= 7'(ex);
		end_y        <= 10'(ey);
		pen_value    <= 8'(pen);
		byte_address <= 14'(addr);
		byte_data    <= 8'(data);
		do @(posedge clk); while (!(cmd_valid && cmd_ready));
	endtask

	// Response side: random stall before each beat, calm stretches with no stall,
	// and one long hold-off so the block backs up and drops cmd_ready while the
	// sender keeps offering.
	initial begin
		int gap;
		int beats;
		bit calm;
		beats = 0;
		calm = 1'b0;
		wait (arst_n);
		@(posedge clk);
		gap = $urandom_range(0, 11);
		forever begin
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			beats++;
			if (beats % 100 == 0) calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 11);
			if (beats == 300) gap = LONG_HOLD;
		end
	end

	initial begin
		int pick, sx, sy, ex, ey, px, py, win_x, win_y, addr;
		win_x = 0;
		win_y = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// fresh canvas reads back zero
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 0, $urandom);
		// address and data extremes, alternating bit patterns
		send_cmd(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, 16383, 255);
		send_cmd(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, 'h1555, 'hAA);
		send_cmd(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, 'h2AAA, 'h55);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 16383, $urandom);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 'h1555, $urandom);
		// full-width horizontal, full pen
		send_cmd(CMD_DRAW, 0, 0, 127, 0, 255, $urandom, $urandom);
		// vertical with both rows far outside the canvas, clamped
		send_cmd(CMD_DRAW, 5, -512, 5, 511, 1, $urandom, $urandom);
		// major span collapses to zero after clamping: nothing drawn, no divide
		send_cmd(CMD_DRAW, 9, -300, 9, -20, 200, $urandom, $urandom);
		// single point, zero deltas
		send_cmd(CMD_DRAW, 64, 64, 64, 64, 9, $urandom, $urandom);
		// x-major, descending x: endpoints swapped
		send_cmd(CMD_DRAW, 100, 10, 20, 60, 77, $urandom, $urandom);
		// y-major, descending y: swapped, minor direction from the swapped ends
		send_cmd(CMD_DRAW, 30, 120, 40, 2, 128, $urandom, $urandom);
		// y-major picked from raw deltas, span from clamped rows
		send_cmd(CMD_DRAW, 0, -512, 127, 511, 200, $urandom, $urandom);
		send_cmd(CMD_DRAW, 0, 300, 120, -400, 150, $urandom, $urandom);
		// x-major, both rows clamp to the bottom edge, raw dy negative
		send_cmd(CMD_DRAW, 3, 200, 120, 150, 60, $urandom, $urandom);
		// zero pen never raises a byte
		send_cmd(CMD_DRAW, 0, 0, 127, 127, 0, $urandom, $urandom);
		// unused command: no effect, zero answer
		send_cmd(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			pixel_addr(64, 0), $urandom);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			pixel_addr(5, 100), $urandom);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			pixel_addr(126, 127), $urandom);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			pixel_addr(60, 35), $urandom);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
			pixel_addr(5, 0), $urandom);
		send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, 'h2AAA, $urandom);

		// --- random part ---
		// Most traffic stays in a 16x16 window that moves every 100 beats, so reads
		// land on pixels that draws and writes just touched.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				sender_calm = ($urandom_range(0, 3) == 0);
				win_x = $urandom_range(0, 112);
				win_y = $urandom_range(0, 112);
			end
			pick = $urandom_range(0, 99);
			px = win_x + $urandom_range(0, 15);
			py = win_y + $urandom_range(0, 15);
			addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : pixel_addr(px, py);
			if (pick < 40) begin
				if ($urandom_range(0, 9) < 7) begin
					sx = win_x + $urandom_range(0, 15);
					ex = win_x + $urandom_range(0, 15);
					sy = win_y + $urandom_range(0, 15);
					ey = win_y + $urandom_range(0, 15);
				end else begin
					// full canvas, rows sometimes anywhere in the signed range
					sx = $urandom_range(0, 127);
					ex = $urandom_range(0, 127);
					sy = $urandom_range(0, 1) ? $urandom_range(0, 127)
						: int'($urandom_range(0, 1023)) - 512;
					ey = $urandom_range(0, 1) ? $urandom_range(0, 127)
						: int'($urandom_range(0, 1023)) - 512;
				end
				send_cmd(CMD_DRAW, sx, sy, ex, ey, $urandom_range(0, 255), $urandom, $urandom);
			end else if (pick < 55) begin
				send_cmd(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, addr,
					$urandom_range(0, 255));
			end else if (pick < 97) begin
				send_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, addr,
					$urandom);
			end else begin
				send_cmd(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
			end
		end
		cmd_valid <= 1'b0;

		// let the checker's outstanding count take in the last beat before polling it
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
rtl/core/tcld_pkg.sv
rtl/core/tcld_div.sv
rtl/core/tcld_canvas.sv
rtl/core/tiled_canvas_line_draw.sv
tb/tcld_canvas_check.sv
tb/tb.sv
